// File: sv/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the bit engine checkers.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define I2CBE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define I2CBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every engine module.
package i2cbe_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned DELAY_W   = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

    // Command codes
    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_STOP     = 3'd1,
        ACT_WRITE    = 3'd2,
        ACT_READ     = 3'd3,
        ACT_SEND_ACK = 3'd4,
        ACT_WAIT_ACK = 3'd5
    } action_t;

    // Sequencer phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_1    = 4'b0010,
        PH_2    = 4'b0100,
        PH_3    = 4'b1000
    } phase_t;

    // Classified tick item passed from front to back through the queue
    typedef struct packed {
        logic                 cmd_ok;
        action_t              action;
        logic [BYTE_BITS-1:0] write_data;
        logic                 ack_level;
        logic                 sda_in;
    } item_t;

    // Result item, scl_out in the lowest bit
    typedef struct packed {
        logic [2:0]           pad;
        logic                 ack_seen;
        logic [BYTE_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 sda_out;
        logic                 scl_out;
    } result_t;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: sv/i2c_master_bit_engine.sv
// I2C master bit engine top level: front end, item queue and sequencer back end.
// Depends on i2cbe_pkg, i2cbe_front, i2cbe_queue and i2cbe_back.
//
// Each input item is one clock tick of the bus: an optional command plus the
// sampled SDA level; each produces exactly one result item with the SCL/SDA
// drive, busy, done, the last read byte and the last slave ack. The block
// takes one item per clock while the output is not stalled. An accepted
// item is queued and then popped into the result register on m_axis. The
// back-end sequencer performs one tick step per cycle while the output slot
// is free or draining, and sets that rate. The queue of QUEUE_DEPTH items
// lets the input keep flowing while a result waits on m_axis_tready.
module i2c_master_bit_engine
    import i2cbe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // delay_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // write_data[7:0], ack_level[8], sda_in[9], zeros
    input  logic [3:0]  s_axis_tuser,  // cmd_valid[0], action[3:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // scl[0], sda[1], busy[2], done[3],
                                       // read_data[11:4], ack_seen[12], zeros
);

    q_stat_t q_stat;
    logic    push, pop, head_valid;
    item_t   push_item, head_item;
    result_t m_result;

    i2cbe_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    i2cbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .q_stat     (q_stat)
    );

    i2cbe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_item   (head_item),
        .head_valid  (head_valid),
        .pop         (pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_result    (m_result)
    );

    assign m_axis_tdata = m_result;

endmodule

// File: sv/i2cbe_front.sv
// Front end: accepts tick items from the input stream and classifies the command.
// Depends on i2cbe_pkg.
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // write_data[7:0], ack_level[8], sda_in[9], zeros
    input  logic [3:0]  s_axis_tuser,  // cmd_valid[0], action[3:1]
    input  q_stat_t     q_stat,
    output logic        push,
    output item_t       push_item
);

    logic [2:0] act_raw;

    assign act_raw = s_axis_tuser[3:1];

    // Ready whenever the queue has room
    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

    // Only codes start..wait-ack start a sequence
    always_comb begin
        push_item.cmd_ok     = s_axis_tuser[0] && (act_raw <= ACT_WAIT_ACK);
        push_item.action     = action_t'(act_raw);
        push_item.write_data = s_axis_tdata[7:0];
        push_item.ack_level  = s_axis_tdata[8];
        push_item.sda_in     = s_axis_tdata[9];
    end

endmodule

// File: sv/i2cbe_queue.sv
// Small item FIFO between front and back of the bit engine.
// Depends on i2cbe_pkg.
module i2cbe_queue
    import i2cbe_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head_item,
    output logic    head_valid,
    output q_stat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign head_valid   = !q_stat.empty;
    assign head_item    = mem[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/i2cbe_back.sv
// Back end: SCL/SDA sequencer, delay register and result output register.
// Depends on i2cbe_pkg.
module i2cbe_back
    import i2cbe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  item_t        head_item,
    input  logic         head_valid,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output result_t      m_result
);

    logic [DELAY_W-1:0]   delay_reg;
    phase_t               phase_reg, phase_next;
    action_t              cur_act_reg, cur_act_next;
    logic [3:0]           bit_idx_reg, bit_idx_next;
    logic [DELAY_W-1:0]   tick_reg, tick_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [BYTE_BITS-1:0] read_reg, read_next;
    logic                 ack_reg, ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 done;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic                 can_step;
    logic [DELAY_W-1:0]   wait_load;
    logic [3:0]           bit_inc;
    logic                 more_bits;

    // Output slot free or being drained
    assign can_step = !out_valid_reg || m_ready;
    assign pop      = head_valid && can_step;
    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

    // Zero delay acts as one tick
    assign wait_load = (delay_reg == '0) ? '0 : delay_reg - 1'b1;
    assign bit_inc   = bit_idx_reg + 4'd1;
    assign more_bits = (bit_inc < 4'(BYTE_BITS));

    // One sequencer step per tick item
    always_comb begin
        phase_next   = phase_reg;
        cur_act_next = cur_act_reg;
        bit_idx_next = bit_idx_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        read_next    = read_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;
        if (phase_reg != PH_IDLE) begin
            if (tick_reg != '0) begin
                tick_next = tick_reg - 1'b1;
            end else begin
                // Wait over: apply the next edges of the sequence
                tick_next = wait_load;
                unique case (cur_act_reg)
                    ACT_START: begin
                        if (phase_reg == PH_1) begin
                            sda_next   = 1'b0;
                            phase_next = PH_2;
                        end else begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end
                    ACT_STOP: begin
                        if (phase_reg == PH_1) begin
                            scl_next   = 1'b1;
                            phase_next = PH_2;
                        end else begin
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    ACT_WRITE: begin
                        if (phase_reg == PH_1) begin
                            scl_next   = 1'b0;
                            phase_next = PH_2;
                        end else if (phase_reg == PH_2) begin
                            bit_idx_next = bit_inc;
                            if (more_bits) begin
                                sda_next   = shift_reg[BYTE_BITS-1];
                                shift_next = {shift_reg[BYTE_BITS-2:0], 1'b0};
                                scl_next   = 1'b1;
                                phase_next = PH_1;
                            end else begin
                                sda_next   = 1'b1;
                                phase_next = PH_3;
                            end
                        end else begin
                            done = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (phase_reg == PH_1) begin
                            if (head_item.sda_in) begin
                                shift_next = shift_reg | (8'h80 >> bit_idx_reg[2:0]);
                            end
                            scl_next   = 1'b0;
                            phase_next = PH_2;
                        end else begin
                            bit_idx_next = bit_inc;
                            if (more_bits) begin
                                scl_next   = 1'b1;
                                phase_next = PH_1;
                            end else begin
                                read_next = shift_reg;
                                done      = 1'b1;
                            end
                        end
                    end
                    ACT_SEND_ACK: begin
                        if (phase_reg == PH_1) begin
                            scl_next   = 1'b0;
                            phase_next = PH_2;
                        end else begin
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    default: begin
                        // wait ack
                        if (phase_reg == PH_1) begin
                            scl_next   = 1'b1;
                            phase_next = PH_2;
                        end else if (phase_reg == PH_2) begin
                            ack_next   = head_item.sda_in;
                            scl_next   = 1'b0;
                            phase_next = PH_3;
                        end else begin
                            done = 1'b1;
                        end
                    end
                endcase
                if (done) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
        end else if (head_item.cmd_ok) begin
            // Accept a command: first edges on this tick
            cur_act_next = head_item.action;
            bit_idx_next = '0;
            tick_next    = wait_load;
            phase_next   = PH_1;
            unique case (head_item.action)
                ACT_START: begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                ACT_STOP: begin
                    sda_next = 1'b0;
                    scl_next = 1'b0;
                end
                ACT_WRITE: begin
                    sda_next   = head_item.write_data[BYTE_BITS-1];
                    shift_next = {head_item.write_data[BYTE_BITS-2:0], 1'b0};
                    scl_next   = 1'b1;
                end
                ACT_READ: begin
                    shift_next = '0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                ACT_SEND_ACK: begin
                    sda_next = head_item.ack_level;
                    scl_next = 1'b1;
                end
                default: begin
                    sda_next = 1'b1;
                end
            endcase
        end
    end

    // Sequencer state, advanced once per consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cur_act_reg <= ACT_START;
            bit_idx_reg <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
            read_reg    <= '0;
            ack_reg     <= 1'b1;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end else if (pop) begin
            phase_reg   <= phase_next;
            cur_act_reg <= cur_act_next;
            bit_idx_reg <= bit_idx_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            read_reg    <= read_next;
            ack_reg     <= ack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    // Delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            delay_reg <= cfg_wr_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_step) begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg.pad       <= '0;
            out_data_reg.ack_seen  <= ack_next;
            out_data_reg.read_data <= read_next;
            out_data_reg.done_res  <= done;
            out_data_reg.busy_res  <= (phase_next != PH_IDLE);
            out_data_reg.sda_out   <= sda_next;
            out_data_reg.scl_out   <= scl_next;
        end
    end

endmodule

// File: sv/i2cbe_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_assert.svh.
`include "i2c_master_bit_engine_assert.svh"

module i2cbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Stalled result holds
    `I2CBE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A done tick never reports busy
    `I2CBE_ASSERT_SAME(a_done_not_busy, m_axis_tvalid, !(m_axis_tdata[3] && m_axis_tdata[2]))

    // With no result pending the queue always has room
    `I2CBE_ASSERT_SAME(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (.*);

// File: test/tb.sv
// Self-checking testbench for i2c_master_bit_engine: streams bus ticks, predicts each
// result item from its own model of the bit sequencer and compares them field by field.
// Depends on i2cbe_pkg and the i2c_master_bit_engine RTL.
module tb;
    import i2cbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int HOLD_CYCLES     = 150;
    localparam int TAIL_CYCLES     = 8;
    localparam int SEGMENT_TICKS   = 170;
    localparam int RANDOM_SEGMENTS = 7;
    localparam logic [15:0] LONG_DELAY = 16'd40;
    // action codes past the last command are ignored by the engine
    localparam logic [2:0] ACT_SPARE_LO = ACT_WAIT_ACK + 3'd1;
    localparam logic [2:0] ACT_SPARE_HI = ACT_SPARE_LO + 3'd1;

    // one bus tick as offered on the input stream
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] action;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_in;
    } bus_tick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // predicted engine state
    phase_t      eng_phase = PH_IDLE;
    action_t     eng_act   = ACT_START;
    logic [3:0]  eng_bit   = '0;
    logic [15:0] eng_wait  = '0;
    logic [7:0]  eng_shift = '0;
    logic [7:0]  eng_rd    = '0;
    logic        eng_ack   = 1'b1;
    logic        eng_scl   = 1'b1;
    logic        eng_sda   = 1'b1;
    logic [15:0] delay_cfg = DELAY_RESET;

    result_t expected_pins_q[$];
    int      mismatch_count = 0;
    int      ticks_sent = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    bit      hold_req = 1'b0;

    i2c_master_bit_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    // ---------------- sequencer prediction ----------------

    // a wait of delay_cfg ticks, zero behaves as one
    function automatic void arm_wait(phase_t nxt);
        eng_wait  = (delay_cfg == 16'd0) ? 16'd0 : delay_cfg - 16'd1;
        eng_phase = nxt;
    endfunction

    function automatic void shift_out_bit();
        eng_sda   = eng_shift[7];
        eng_shift = eng_shift << 1;
        eng_scl   = 1'b1;
        arm_wait(PH_1);
    endfunction

    // end of a wait: next edges; returns 1 when the command completes
    function automatic logic finish_wait(logic sda);
        case (eng_act)
            ACT_START: begin
                if (eng_phase == PH_1) begin
                    eng_sda = 1'b0;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                eng_scl = 1'b0;
            end
            ACT_STOP: begin
                if (eng_phase == PH_1) begin
                    eng_scl = 1'b1;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                eng_sda = 1'b1;
            end
            ACT_WRITE: begin
                if (eng_phase == PH_1) begin
                    eng_scl = 1'b0;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                if (eng_phase == PH_2) begin
                    eng_bit = eng_bit + 4'd1;
                    if (eng_bit < BYTE_BITS) begin
                        shift_out_bit();
                    end else begin
                        eng_sda = 1'b1;
                        arm_wait(PH_3);
                    end
                    return 1'b0;
                end
            end
            ACT_READ: begin
                if (eng_phase == PH_1) begin
                    if (sda) eng_shift = eng_shift | (8'h80 >> eng_bit[2:0]);
                    eng_scl = 1'b0;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                eng_bit = eng_bit + 4'd1;
                if (eng_bit < BYTE_BITS) begin
                    eng_scl = 1'b1;
                    arm_wait(PH_1);
                    return 1'b0;
                end
                eng_rd = eng_shift;
            end
            ACT_SEND_ACK: begin
                if (eng_phase == PH_1) begin
                    eng_scl = 1'b0;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                eng_sda = 1'b1;
            end
            default: begin
                // slave ack: release, clock high, sample, clock low
                if (eng_phase == PH_1) begin
                    eng_scl = 1'b1;
                    arm_wait(PH_2);
                    return 1'b0;
                end
                if (eng_phase == PH_2) begin
                    eng_ack = sda;
                    eng_scl = 1'b0;
                    arm_wait(PH_3);
                    return 1'b0;
                end
            end
        endcase
        eng_phase = PH_IDLE;
        eng_wait  = '0;
        return 1'b1;
    endfunction

    // first edges of a command, on the tick that takes it
    function automatic void load_command(bus_tick_t t);
        eng_act = action_t'(t.action);
        eng_bit = '0;
        case (eng_act)
            ACT_START: begin
                eng_sda = 1'b1;
                eng_scl = 1'b1;
                arm_wait(PH_1);
            end
            ACT_STOP: begin
                eng_sda = 1'b0;
                eng_scl = 1'b0;
                arm_wait(PH_1);
            end
            ACT_WRITE: begin
                eng_shift = t.write_data;
                shift_out_bit();
            end
            ACT_READ: begin
                eng_shift = '0;
                eng_sda   = 1'b1;
                eng_scl   = 1'b1;
                arm_wait(PH_1);
            end
            ACT_SEND_ACK: begin
                eng_sda = t.ack_level;
                eng_scl = 1'b1;
                arm_wait(PH_1);
            end
            default: begin
                eng_sda = 1'b1;
                arm_wait(PH_1);
            end
        endcase
    endfunction

    // one tick of the engine; returns the pin/status item it produces
    function automatic result_t step_engine(bus_tick_t t);
        result_t r;
        logic    done;
        done = 1'b0;
        if (eng_phase != PH_IDLE) begin
            if (eng_wait != 16'd0) eng_wait = eng_wait - 16'd1;
            else done = finish_wait(t.sda_in);
        end else if (t.cmd_valid && t.action <= ACT_WAIT_ACK) begin
            load_command(t);
        end
        r           = '0;
        r.scl_out   = eng_scl;
        r.sda_out   = eng_sda;
        r.busy_res  = (eng_phase != PH_IDLE);
        r.done_res  = done;
        r.read_data = eng_rd;
        r.ack_seen  = eng_ack;
        return r;
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls, one long hold on request
    initial begin : result_sink
        result_t got;
        result_t want;
        int      stall;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (m_axis_tvalid !== 1'b1 || !aresetn) @(posedge aclk);
            got = result_t'(m_axis_tdata);
            if (expected_pins_q.size() == 0) begin
                $error("result item %0h with nothing predicted", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_pins_q.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_tick(bus_tick_t t);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {t.action, t.cmd_valid};
        s_axis_tdata  <= {6'd0, t.sda_in, t.ack_level, t.write_data};
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        expected_pins_q.push_back(step_engine(t));
        ticks_sent++;
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_pins_q.size() != 0);
    endtask

    function automatic bus_tick_t filler_tick(bit offer);
        bus_tick_t t;
        t.cmd_valid  = offer;
        t.action     = 3'($urandom_range(0, 7));
        t.write_data = 8'($urandom);
        t.ack_level  = 1'($urandom);
        t.sda_in     = 1'($urandom);
        return t;
    endfunction

    // negative mode: random line, else the given level
    function automatic logic line_level(int mode);
        return (mode < 0) ? 1'($urandom) : 1'(mode);
    endfunction

    function automatic bit nag();
        return ($urandom_range(0, 6) == 0);
    endfunction

    // offer a command, then tick until the engine is idle again;
    // with pester set every busy tick also carries a stray command
    task automatic do_command(logic [2:0] act, logic [7:0] data, logic ackl, int sda_mode,
                              bit pester);
        bus_tick_t t;
        t.cmd_valid  = 1'b1;
        t.action     = act;
        t.write_data = data;
        t.ack_level  = ackl;
        t.sda_in     = line_level(sda_mode);
        send_tick(t);
        while (eng_phase != PH_IDLE) begin
            t        = filler_tick(pester);
            t.sda_in = line_level(sda_mode);
            send_tick(t);
        end
    endtask

    // delay register changes only with the engine idle and nothing in flight
    task automatic set_delay(logic [15:0] v);
        while (eng_phase != PH_IDLE) send_tick(filler_tick(1'b0));
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        delay_cfg = v;
    endtask

    // start, address, ack, a few data bytes, stop
    task automatic run_transfer();
        int n;
        do_command(ACT_START, 8'($urandom), 1'($urandom), -1, nag());
        do_command(ACT_WRITE, 8'($urandom), 1'($urandom), -1, nag());
        do_command(ACT_WAIT_ACK, 8'($urandom), 1'($urandom), -1, nag());
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(0, 1) != 0) begin
                do_command(ACT_WRITE, 8'($urandom), 1'($urandom), -1, nag());
                do_command(ACT_WAIT_ACK, 8'($urandom), 1'($urandom), -1, nag());
            end else begin
                do_command(ACT_READ, 8'($urandom), 1'($urandom), -1, nag());
                do_command(ACT_SEND_ACK, 8'($urandom), 1'($urandom), -1, nag());
            end
        end
        do_command(ACT_STOP, 8'($urandom), 1'($urandom), -1, nag());
    endtask

    // stray commands, spare codes and quiet ticks
    task automatic run_noise();
        bus_tick_t t;
        int        n;
        case ($urandom_range(0, 2))
            0: begin
                t = filler_tick(1'b1);
                do_command(t.action, t.write_data, t.ack_level, -1, nag());
            end
            1: begin
                n = $urandom_range(1, 8);
                repeat (n) send_tick(filler_tick(1'($urandom)));
            end
            default: do_command(ACT_STOP, 8'($urandom), 1'($urandom), -1, nag());
        endcase
    endtask

    // ---------------- tests ----------------

    // reset delay of 10 ticks, idle pins before any command
    task automatic test_reset_delay();
        repeat (4) send_tick(filler_tick(1'b0));
        do_command(ACT_START, 8'h00, 1'b0, -1, 1'b0);
        do_command(ACT_STOP, 8'hFF, 1'b1, -1, 1'b0);
    endtask

    // every command and the data extremes, then zero delay with busy commands
    task automatic test_commands();
        set_delay(16'd1);
        do_command(ACT_START, 8'h00, 1'b0, -1, 1'b0);
        do_command(ACT_WRITE, 8'h00, 1'b0, -1, 1'b0);
        do_command(ACT_WRITE, 8'hFF, 1'b1, -1, 1'b0);
        do_command(ACT_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
        do_command(ACT_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0);
        do_command(ACT_READ, 8'h00, 1'b0, 1, 1'b0);
        do_command(ACT_SEND_ACK, 8'h00, 1'b0, -1, 1'b0);
        do_command(ACT_READ, 8'hFF, 1'b1, 0, 1'b0);
        do_command(ACT_SEND_ACK, 8'hFF, 1'b1, -1, 1'b0);
        do_command(ACT_READ, 8'h5A, 1'b0, -1, 1'b0);
        do_command(ACT_STOP, 8'h00, 1'b0, -1, 1'b0);
        do_command(ACT_SPARE_LO, 8'hFF, 1'b1, -1, 1'b0);
        do_command(ACT_SPARE_HI, 8'hFF, 1'b1, -1, 1'b0);
        set_delay(16'd0);
        do_command(ACT_START, 8'h3C, 1'b1, -1, 1'b1);
        do_command(ACT_WRITE, 8'hA5, 1'b1, -1, 1'b1);
        do_command(ACT_WAIT_ACK, 8'h00, 1'b0, -1, 1'b1);
        do_command(ACT_READ, 8'h00, 1'b0, -1, 1'b1);
        do_command(ACT_STOP, 8'h00, 1'b0, -1, 1'b1);
    endtask

    // long receiver hold while ticks keep coming, so the input backs up
    task automatic test_receiver_hold();
        set_delay(16'd1);
        hold_req = 1'b1;
        run_transfer();
        wait_drained();
    endtask

    // sender stops after each command until every result is back
    task automatic test_sender_pause();
        repeat (4) begin
            do_command(3'($urandom_range(0, 5)), 8'($urandom), 1'($urandom), -1, 1'b0);
            wait_drained();
        end
    endtask

    // random traffic over several delay settings
    task automatic test_random_traffic();
        int          seg_end;
        logic [15:0] d;
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case ($urandom_range(0, 4))
                0:       d = 16'd0;
                1, 2:    d = 16'd1;
                3:       d = 16'd2;
                default: d = 16'($urandom_range(3, 5));
            endcase
            set_delay(d);
            idle_on = ($urandom_range(0, 3) != 0);
            seg_end = ticks_sent + SEGMENT_TICKS;
            while (ticks_sent < seg_end) begin
                if ($urandom_range(0, 4) != 0) run_transfer();
                else run_noise();
            end
        end
        idle_on = 1'b1;
    endtask

    // long delay: one start condition with wide waits, run to completion, no idling
    task automatic test_long_delay();
        set_delay(LONG_DELAY);
        idle_on = 1'b0;
        do_command(ACT_START, 8'h00, 1'b0, -1, 1'b0);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_delay();
        test_commands();
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic();
        test_long_delay();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
